// ===== hdl/ecz_pkg.sv =====
// ----------------------------------------------------------------------------
// ecz_pkg
// Shared widths, reset values, register codes, item types and the arctangent
// table for the ECI to ECEF earth-rotation pipeline.
// ----------------------------------------------------------------------------
package ecz_pkg;

  localparam int POS_W       = 36;
  localparam int TIME_W      = 42;
  localparam int SAT_W       = 6;
  localparam int EPOCH_W     = 10;
  localparam int GUARD       = 16;
  localparam int CW          = 56;   // rotator datapath, Q16 millimetres
  localparam int ANG_W       = 34;   // residual angle, 2^-32 turn
  localparam int DIV_W       = 37;   // divisor and remainder width
  localparam int MOD_STEPS   = TIME_W;
  localparam int FRAC_STEPS  = 32;
  localparam int DIV_STAGES  = MOD_STEPS + 1 + FRAC_STEPS;
  localparam int ROTATION_STAGES_DEF = 32;

  localparam logic [16:0] PERIOD_RST = 17'd86400;
  localparam logic [30:0] THRESH_RST = 31'd1000000;

  // gain inverse 2608131496 / 2^32, split in two 16-bit halves
  localparam logic [15:0] KINV_HI = 16'd39796;
  localparam logic [15:0] KINV_LO = 16'd60840;

  // register index (address bit 2)
  localparam logic REG_PERIOD = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  typedef struct packed {
    logic [SAT_W-1:0]          sat_id;
    logic [EPOCH_W-1:0]        epoch_index;
    logic signed [POS_W-1:0]   z;
    logic signed [TIME_W-1:0]  tms;
    logic signed [CW-1:0]      cx;
    logic signed [CW-1:0]      cy;
    logic                      is_ms;
    logic                      neg;
    logic [TIME_W-1:0]         mag;
    logic [DIV_W-1:0]          rem;
    logic [31:0]               phase;
  } ecz_item_t;

  typedef struct packed {
    logic [SAT_W-1:0]          sat_id;
    logic [EPOCH_W-1:0]        epoch_index;
    logic signed [POS_W-1:0]   z;
    logic signed [TIME_W-1:0]  tms;
    logic signed [CW-1:0]      cx;
    logic signed [CW-1:0]      cy;
    logic signed [ANG_W-1:0]   ang;
  } ecz_rot_t;

  // atan(2^-i) in 2^-32 turn, rounded; zero from stage 31 on
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] a;
    case (i)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      24: a = 32'd41;
      25: a = 32'd20;
      26: a = 32'd10;
      27: a = 32'd5;
      28: a = 32'd3;
      29: a = 32'd1;
      30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/ecz_div.sv =====
// ----------------------------------------------------------------------------
// ecz_div
// Pipelined restoring divider: one bit per stage. First the time magnitude
// is reduced modulo the period, then negative times are wrapped, then 32
// fraction bits of remainder / period form the phase.
// ----------------------------------------------------------------------------
module ecz_div import ecz_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic [DIV_W-1:0] d_s,
  input  logic [DIV_W-1:0] d_ms,
  input  logic             in_valid,
  input  ecz_item_t        in_item,
  output logic             out_valid,
  output ecz_item_t        out_item
);

  logic [DIV_STAGES:0] vld;
  ecz_item_t           item [0:DIV_STAGES];

  assign vld[0]  = in_valid;
  assign item[0] = in_item;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    ecz_item_t        nxt;
    logic [DIV_W-1:0] d;
    logic [DIV_W:0]   u;

    // one remainder step, wrap, or one fraction bit
    always_comb begin
      nxt = item[k];
      d   = item[k].is_ms ? d_ms : d_s;
      u   = '0;
      if (k < MOD_STEPS) begin
        u       = {item[k].rem, item[k].mag[TIME_W-1]};
        nxt.mag = {item[k].mag[TIME_W-2:0], 1'b0};
        if (u >= {1'b0, d}) nxt.rem = DIV_W'(u - {1'b0, d});
        else nxt.rem = u[DIV_W-1:0];
      end else if (k == MOD_STEPS) begin
        if (item[k].neg && (item[k].rem != '0)) nxt.rem = d - item[k].rem;
      end else begin
        u = {item[k].rem, 1'b0};
        if (u >= {1'b0, d}) begin
          nxt.rem   = DIV_W'(u - {1'b0, d});
          nxt.phase = {item[k].phase[30:0], 1'b1};
        end else begin
          nxt.rem   = u[DIV_W-1:0];
          nxt.phase = {item[k].phase[30:0], 1'b0};
        end
      end
    end

    // advance valid
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    // advance payload
    always_ff @(posedge clk) begin
      if (adv) begin
        item[k+1] <= nxt;
      end
    end
  end

  assign out_valid = vld[DIV_STAGES];
  assign out_item  = item[DIV_STAGES];

endmodule

// ===== hdl/ecz_cordic.sv =====
// ----------------------------------------------------------------------------
// ecz_cordic
// Pipelined CORDIC rotator, one micro-rotation per stage, driving the
// residual angle toward zero.
// ----------------------------------------------------------------------------
module ecz_cordic import ecz_pkg::*; #(
  parameter int STAGES = ROTATION_STAGES_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  logic     in_valid,
  input  ecz_rot_t in_item,
  output logic     out_valid,
  output ecz_rot_t out_item
);

  logic [STAGES:0] vld;
  ecz_rot_t        rot [0:STAGES];

  assign vld[0] = in_valid;
  assign rot[0] = in_item;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    ecz_rot_t                nxt;
    logic signed [CW-1:0]    dx;
    logic signed [CW-1:0]    dy;
    logic signed [ANG_W-1:0] a;

    // rotate by +/- atan(2^-i)
    always_comb begin
      nxt = rot[i];
      dx  = $signed(rot[i].cy) >>> i;
      dy  = $signed(rot[i].cx) >>> i;
      a   = $signed({2'b00, atan_turn(i)});
      if (!rot[i].ang[ANG_W-1]) begin
        nxt.cx  = rot[i].cx + dx;
        nxt.cy  = rot[i].cy - dy;
        nxt.ang = rot[i].ang - a;
      end else begin
        nxt.cx  = rot[i].cx - dx;
        nxt.cy  = rot[i].cy + dy;
        nxt.ang = rot[i].ang + a;
      end
    end

    // advance valid
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= vld[i];
      end
    end

    // advance payload
    always_ff @(posedge clk) begin
      if (adv) begin
        rot[i+1] <= nxt;
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign out_item  = rot[STAGES];

endmodule

// ===== hdl/eci_to_ecef_z_rotation.sv =====
// ----------------------------------------------------------------------------
// eci_to_ecef_z_rotation
// Rotates tagged ECI position samples about z by the earth angle at their
// timestamp, giving ECEF positions and the time in milliseconds.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  input    | in_valid / in_ready   | sat_id epoch_index eci_x/y/z time_raw
//  output   | out_valid / out_ready | out_sat_id out_epoch_index ecef_x/y/z
//           |                       | time_ms
//  config   | APB psel/penable      | day_period_seconds, millisecond_threshold
//
//  One item per cycle. The pipeline is two input stages (prescale multiply,
//  sum), 75 divider stages for the phase (one quotient bit each), a quadrant
//  stage, the CORDIC stages and the output register. Items with zero
//  position or zero time are dropped at entry.
//  A stall at the output holds the whole pipeline; nothing is lost.
//  Reset is synchronous and clears the valid bits and configuration registers.
// ----------------------------------------------------------------------------
module eci_to_ecef_z_rotation import ecz_pkg::*; #(
  parameter int ROTATION_STAGES = ROTATION_STAGES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SAT_W-1:0]         sat_id,
  input  logic [EPOCH_W-1:0]       epoch_index,
  input  logic signed [POS_W-1:0]  eci_x,
  input  logic signed [POS_W-1:0]  eci_y,
  input  logic signed [POS_W-1:0]  eci_z,
  input  logic signed [TIME_W-1:0] time_raw,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [SAT_W-1:0]         out_sat_id,
  output logic [EPOCH_W-1:0]       out_epoch_index,
  output logic signed [POS_W-1:0]  ecef_x,
  output logic signed [POS_W-1:0]  ecef_y,
  output logic signed [POS_W-1:0]  ecef_z,
  output logic signed [TIME_W-1:0] time_ms
);

  localparam logic signed [TIME_W+10:0] TMS_MAX = {{12{1'b0}}, {(TIME_W-1){1'b1}}};
  localparam logic signed [TIME_W+10:0] TMS_MIN = {{12{1'b1}}, {(TIME_W-1){1'b0}}};
  localparam logic signed [CW:0] POS_MAX = {{(CW-POS_W+2){1'b0}}, {(POS_W-1){1'b1}}};
  localparam logic signed [CW:0] POS_MIN = {{(CW-POS_W+2){1'b1}}, {(POS_W-1){1'b0}}};

  logic [16:0]      day_period_seconds;
  logic [30:0]      millisecond_threshold;
  logic [DIV_W-1:0] d_s;
  logic [DIV_W-1:0] d_ms;
  logic             d_zero;
  logic             adv;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      day_period_seconds    <= PERIOD_RST;
      millisecond_threshold <= THRESH_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_PERIOD: day_period_seconds    <= pwdata[16:0];
        REG_THRESH: millisecond_threshold <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PERIOD: prdata = {15'b0, day_period_seconds};
      REG_THRESH: prdata = {1'b0, millisecond_threshold};
      default:    prdata = '0;
    endcase
  end

  // period in time units: 1024*P for seconds, 1024000*P for milliseconds
  always_ff @(posedge clk) begin
    d_s  <= {10'b0, day_period_seconds, 10'b0};
    d_ms <= {({10'b0, day_period_seconds} * 27'd1000), 10'b0};
  end
  assign d_zero = (day_period_seconds == '0);

  // whole pipeline moves when the output register is empty or being read
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage A: filter, classify time, multiply
  logic [POS_W-1:0]  xm;
  logic [POS_W-1:0]  ym;
  logic              keep;
  logic              is_ms_in;
  logic              a_vld;
  logic [SAT_W-1:0]  a_sat;
  logic [EPOCH_W-1:0] a_ep;
  logic signed [POS_W-1:0]  a_z;
  logic signed [TIME_W-1:0] a_t;
  logic signed [TIME_W+10:0] a_tprod;
  logic              a_is_ms;
  logic              a_xneg;
  logic              a_yneg;
  logic [51:0]       a_xa;
  logic [51:0]       a_xb;
  logic [51:0]       a_ya;
  logic [51:0]       a_yb;

  assign xm   = eci_x[POS_W-1] ? POS_W'(-eci_x) : eci_x;
  assign ym   = eci_y[POS_W-1] ? POS_W'(-eci_y) : eci_y;
  assign keep = ((eci_x != '0) || (eci_y != '0) || (eci_z != '0)) && (time_raw != '0);
  assign is_ms_in = time_raw > $signed({1'b0, millisecond_threshold, 10'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= in_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_sat   <= sat_id;
      a_ep    <= epoch_index;
      a_z     <= eci_z;
      a_t     <= time_raw;
      a_tprod <= (TIME_W+11)'(time_raw) * (TIME_W+11)'(1000);
      a_is_ms <= is_ms_in;
      a_xneg  <= eci_x[POS_W-1];
      a_yneg  <= eci_y[POS_W-1];
      a_xa    <= {16'b0, xm} * {36'b0, KINV_HI};
      a_xb    <= {16'b0, xm} * {36'b0, KINV_LO};
      a_ya    <= {16'b0, ym} * {36'b0, KINV_HI};
      a_yb    <= {16'b0, ym} * {36'b0, KINV_LO};
    end
  end

  // stage B: finish prescale, saturate time, seed divider
  logic [51:0] rx;
  logic [51:0] ry;
  logic signed [TIME_W-1:0] tms_b;
  ecz_item_t   b_next;
  ecz_item_t   b_item;
  logic        b_vld;

  assign rx = a_xa + {16'b0, a_xb[51:16]};
  assign ry = a_ya + {16'b0, a_yb[51:16]};

  always_comb begin
    if (a_is_ms) tms_b = a_t;
    else if (a_tprod > TMS_MAX) tms_b = TMS_MAX[TIME_W-1:0];
    else if (a_tprod < TMS_MIN) tms_b = TMS_MIN[TIME_W-1:0];
    else tms_b = a_tprod[TIME_W-1:0];
  end

  always_comb begin
    b_next.sat_id      = a_sat;
    b_next.epoch_index = a_ep;
    b_next.z           = a_z;
    b_next.tms         = tms_b;
    b_next.cx          = a_xneg ? -$signed({4'b0, rx}) : $signed({4'b0, rx});
    b_next.cy          = a_yneg ? -$signed({4'b0, ry}) : $signed({4'b0, ry});
    b_next.is_ms       = a_is_ms;
    b_next.neg         = a_t[TIME_W-1];
    b_next.mag         = a_t[TIME_W-1] ? TIME_W'(-a_t) : a_t;
    b_next.rem         = '0;
    b_next.phase       = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_item <= b_next;
    end
  end

  // phase divider
  logic      dv_vld;
  ecz_item_t dv_item;

  ecz_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .d_s       (d_s),
    .d_ms      (d_ms),
    .in_valid  (b_vld),
    .in_item   (b_item),
    .out_valid (dv_vld),
    .out_item  (dv_item)
  );

  // stage C: exact quarter turn, residual angle
  logic [31:0] ph;
  ecz_rot_t    c_next;
  ecz_rot_t    c_item;
  logic        c_vld;

  assign ph = d_zero ? 32'd0 : dv_item.phase;

  always_comb begin
    c_next.sat_id      = dv_item.sat_id;
    c_next.epoch_index = dv_item.epoch_index;
    c_next.z           = dv_item.z;
    c_next.tms         = dv_item.tms;
    c_next.ang         = $signed({4'b0, ph[29:0]});
    case (ph[31:30])
      2'd1: begin
        c_next.cx = dv_item.cy;
        c_next.cy = -dv_item.cx;
      end
      2'd2: begin
        c_next.cx = -dv_item.cx;
        c_next.cy = -dv_item.cy;
      end
      2'd3: begin
        c_next.cx = -dv_item.cy;
        c_next.cy = dv_item.cx;
      end
      default: begin
        c_next.cx = dv_item.cx;
        c_next.cy = dv_item.cy;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (adv) begin
      c_vld <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_item <= c_next;
    end
  end

  // rotator
  logic     cr_vld;
  ecz_rot_t cr_item;

  ecz_cordic #(
    .STAGES (ROTATION_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (c_vld),
    .in_item   (c_item),
    .out_valid (cr_vld),
    .out_item  (cr_item)
  );

  // output register: round half up, saturate
  logic signed [CW:0] xr;
  logic signed [CW:0] yr;
  logic signed [POS_W-1:0] xs;
  logic signed [POS_W-1:0] ys;

  assign xr = ((CW+1)'(cr_item.cx) + (CW+1)'(2**(GUARD-1))) >>> GUARD;
  assign yr = ((CW+1)'(cr_item.cy) + (CW+1)'(2**(GUARD-1))) >>> GUARD;

  always_comb begin
    if (xr > POS_MAX) xs = POS_MAX[POS_W-1:0];
    else if (xr < POS_MIN) xs = POS_MIN[POS_W-1:0];
    else xs = xr[POS_W-1:0];
    if (yr > POS_MAX) ys = POS_MAX[POS_W-1:0];
    else if (yr < POS_MIN) ys = POS_MIN[POS_W-1:0];
    else ys = yr[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= cr_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sat_id      <= cr_item.sat_id;
      out_epoch_index <= cr_item.epoch_index;
      ecef_x          <= xs;
      ecef_y          <= ys;
      ecef_z          <= cr_item.z;
      time_ms         <= cr_item.tms;
    end
  end

  // checks
  a_drop_absent_time: assert property (@(posedge clk) disable iff (rst)
    a_vld |-> (a_t != '0))
    else $error("item with zero time entered the pipeline");

  a_rem_below_period: assert property (@(posedge clk) disable iff (rst)
    (dv_vld && !d_zero) |->
      (dv_item.rem < (dv_item.is_ms ? d_ms : d_s)))
    else $error("divider remainder not below period");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !a_vld && !c_vld)
    else $error("pipeline not empty after reset");

endmodule
